/* hw/rtl/dda_pkg.sv */
// ----------------------------------------------------------------------------
// dda_pkg
// Shared constants and types of the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int XW            = 6;
  localparam int YW            = 5;
  localparam int STEP_W        = (XW > YW) ? XW : YW;
  localparam int COUNT_W       = STEP_W + 1;
  localparam int CANVAS_WIDTH  = 64;
  localparam int CANVAS_HEIGHT = 32;
  localparam int FRACTION_BITS = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int MAX_PIXELS    = 1 << STEP_W;

  localparam int IN_FIELDS_W   = 2 * XW + 2 * YW;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = XW + YW;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    FE_IDLE = 3'b001,
    FE_DIV  = 3'b010,
    FE_PUSH = 3'b100
  } fe_state_e;

endpackage

/* hw/rtl/dda_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: one segment in, one pixel stream with a last marker out.
// ----------------------------------------------------------------------------
//  channel   dir  transaction   payload
//  s_axis    in   one segment   tdata: start_x, start_y, end_x, end_y
//  m_axis    out  one pixel     tdata: pixel_x, pixel_y; tlast: last_pixel
//
//  A segment of n steps emits n+1 pixels, one per cycle while m_axis is not
//  stalled, once the emitter has loaded it. The front end divides a non-zero
//  segment in FE_DIV and then pushes it to the queue in FE_PUSH; a zero-length
//  segment skips the division. This work overlaps the previous segment's
//  emission through a 2-entry queue.
//  Reset is asynchronous, active low, and leaves the block idle and empty.
//  Stalls on m_axis hold the output register; s_axis is refused from an
//  acceptance until the front end has pushed that segment into the queue.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int FRACTION_BITS = dda_pkg::FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_x[5:0], start_y[10:6], end_x[16:11], end_y[21:17], zeros above
  input  logic [dda_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x[5:0], pixel_y[10:6], zeros above
  output logic [dda_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int XW      = dda_pkg::XW;
  localparam int YW      = dda_pkg::YW;
  localparam int INC_W   = FRACTION_BITS + 2;
  localparam int ENTRY_W = 2 * INC_W + XW + YW + dda_pkg::STEP_W;

  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_entry;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_entry;
  logic [XW-1:0]      pixel_x;
  logic [YW-1:0]      pixel_y;

  dda_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .start_x_i    (s_axis_tdata[XW-1:0]),
    .start_y_i    (s_axis_tdata[XW +: YW]),
    .end_x_i      (s_axis_tdata[XW + YW +: XW]),
    .end_y_i      (s_axis_tdata[2 * XW + YW +: YW]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .entry_o      (push_entry)
  );

  dda_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (dda_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_entry),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_entry)
  );

  dda_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (pop_valid),
    .entry_ready_o (pop_ready),
    .entry_i       (pop_entry),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .last_pixel_o  (m_axis_tlast)
  );

  assign m_axis_tdata = dda_pkg::OUT_TDATA_W'({pixel_y, pixel_x});

endmodule

/* hw/rtl/dda_div.sv */
// ----------------------------------------------------------------------------
// dda_div
// Restoring divider, one quotient bit per cycle: (num << FRAC_W) / den.
// ----------------------------------------------------------------------------
module dda_div #(
  parameter int NUM_W  = dda_pkg::STEP_W,
  parameter int FRAC_W = dda_pkg::FRACTION_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NUM_W-1:0]        num_i,
  input  logic [NUM_W-1:0]        den_i,
  output logic                    done_o,
  output logic [NUM_W+FRAC_W-1:0] quo_o
);

  localparam int DVD_W = NUM_W + FRAC_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [NUM_W-1:0] rem_q;
  logic [NUM_W-1:0] den_q;
  logic [DVD_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [NUM_W:0]   rem_sh;
  logic [NUM_W:0]   rem_new;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    fits    = rem_sh >= {1'b0, den_q};
    rem_new = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DVD_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, {FRAC_W{1'b0}}};
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= rem_new[NUM_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* hw/rtl/dda_front.sv */
// ----------------------------------------------------------------------------
// dda_front
// Clamps a segment, classifies it, and computes its per-step increments.
// ----------------------------------------------------------------------------
module dda_front #(
  parameter  int FRACTION_BITS = dda_pkg::FRACTION_BITS,
  localparam int INC_W   = FRACTION_BITS + 2,
  localparam int ENTRY_W = 2 * INC_W + dda_pkg::XW + dda_pkg::YW + dda_pkg::STEP_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [dda_pkg::XW-1:0] start_x_i,
  input  logic [dda_pkg::YW-1:0] start_y_i,
  input  logic [dda_pkg::XW-1:0] end_x_i,
  input  logic [dda_pkg::YW-1:0] end_y_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output logic [ENTRY_W-1:0]     entry_o
);

  localparam int XW     = dda_pkg::XW;
  localparam int YW     = dda_pkg::YW;
  localparam int STEP_W = dda_pkg::STEP_W;
  localparam int QUO_W  = STEP_W + FRACTION_BITS;

  dda_pkg::fe_state_e state_q, state_d;

  logic [XW-1:0]     sx, ex, sx_q;
  logic [YW-1:0]     sy, ey, sy_q;
  logic signed [XW:0] dx;
  logic signed [YW:0] dy;
  logic [XW-1:0]     adx;
  logic [YW-1:0]     ady;
  logic [STEP_W-1:0] adx_w, ady_w, steps, steps_q;
  logic              xneg_q, yneg_q, zero_q;
  logic              accept, div_start, x_done, y_done, div_done;
  logic [QUO_W-1:0]  x_quo, y_quo;
  logic [INC_W-1:0]  x_mag, y_mag, x_inc, y_inc;

  always_comb begin
    sx = start_x_i;
    if (int'(start_x_i) > dda_pkg::CANVAS_WIDTH - 1) sx = XW'(dda_pkg::CANVAS_WIDTH - 1);
    ex = end_x_i;
    if (int'(end_x_i) > dda_pkg::CANVAS_WIDTH - 1) ex = XW'(dda_pkg::CANVAS_WIDTH - 1);
    sy = start_y_i;
    if (int'(start_y_i) > dda_pkg::CANVAS_HEIGHT - 1) sy = YW'(dda_pkg::CANVAS_HEIGHT - 1);
    ey = end_y_i;
    if (int'(end_y_i) > dda_pkg::CANVAS_HEIGHT - 1) ey = YW'(dda_pkg::CANVAS_HEIGHT - 1);
    dx    = $signed({1'b0, ex}) - $signed({1'b0, sx});
    dy    = $signed({1'b0, ey}) - $signed({1'b0, sy});
    adx   = dx[XW] ? XW'(-dx) : dx[XW-1:0];
    ady   = dy[YW] ? YW'(-dy) : dy[YW-1:0];
    adx_w = STEP_W'(adx);
    ady_w = STEP_W'(ady);
    steps = (adx_w > ady_w) ? adx_w : ady_w;
  end

  assign in_ready_o = (state_q == dda_pkg::FE_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign div_start  = accept && (steps != '0);
  assign div_done   = x_done && y_done;

  dda_div #(
    .NUM_W  (STEP_W),
    .FRAC_W (FRACTION_BITS)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (adx_w),
    .den_i   (steps),
    .done_o  (x_done),
    .quo_o   (x_quo)
  );

  dda_div #(
    .NUM_W  (STEP_W),
    .FRAC_W (FRACTION_BITS)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ady_w),
    .den_i   (steps),
    .done_o  (y_done),
    .quo_o   (y_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dda_pkg::FE_IDLE: begin
        if (accept) state_d = (steps == '0) ? dda_pkg::FE_PUSH : dda_pkg::FE_DIV;
      end
      dda_pkg::FE_DIV: begin
        if (div_done) state_d = dda_pkg::FE_PUSH;
      end
      dda_pkg::FE_PUSH: begin
        if (push_ready_i) state_d = dda_pkg::FE_IDLE;
      end
      default: state_d = dda_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dda_pkg::FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q    <= sx;
      sy_q    <= sy;
      steps_q <= steps;
      xneg_q  <= dx[XW];
      yneg_q  <= dy[YW];
      zero_q  <= (steps == '0);
    end
  end

  always_comb begin
    x_mag = {1'b0, x_quo[FRACTION_BITS:0]};
    y_mag = {1'b0, y_quo[FRACTION_BITS:0]};
    if (zero_q) begin
      x_inc = '0;
      y_inc = '0;
    end else begin
      x_inc = xneg_q ? (-x_mag) : x_mag;
      y_inc = yneg_q ? (-y_mag) : y_mag;
    end
  end

  assign push_valid_o = (state_q == dda_pkg::FE_PUSH);
  assign entry_o      = {x_inc, y_inc, sx_q, sy_q, steps_q};

endmodule

/* hw/rtl/dda_queue.sv */
// ----------------------------------------------------------------------------
// dda_queue
// Small FIFO between the increment front end and the pixel emitter.
// ----------------------------------------------------------------------------
module dda_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dda_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

/* hw/rtl/dda_back.sv */
// ----------------------------------------------------------------------------
// dda_back
// Steps the fixed-point accumulators and emits one pixel per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module dda_back #(
  parameter  int FRACTION_BITS = dda_pkg::FRACTION_BITS,
  localparam int INC_W   = FRACTION_BITS + 2,
  localparam int ENTRY_W = 2 * INC_W + dda_pkg::XW + dda_pkg::YW + dda_pkg::STEP_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   entry_valid_i,
  output logic                   entry_ready_o,
  input  logic [ENTRY_W-1:0]     entry_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [dda_pkg::XW-1:0] pixel_x_o,
  output logic [dda_pkg::YW-1:0] pixel_y_o,
  output logic                   last_pixel_o
);

  localparam int XW      = dda_pkg::XW;
  localparam int YW      = dda_pkg::YW;
  localparam int STEP_W  = dda_pkg::STEP_W;
  localparam int COUNT_W = dda_pkg::COUNT_W;
  localparam int XAW     = XW + FRACTION_BITS + 1;
  localparam int YAW     = YW + FRACTION_BITS + 1;

  logic signed [INC_W-1:0] e_x_inc, e_y_inc, x_inc_q, y_inc_q;
  logic [XW-1:0]           e_sx;
  logic [YW-1:0]           e_sy;
  logic [STEP_W-1:0]       e_steps;
  logic signed [XAW-1:0]   x_acc_q;
  logic signed [YAW-1:0]   y_acc_q;
  logic [COUNT_W-1:0]      left_q;
  logic                    busy_q, out_valid_q;
  logic [XW-1:0]           pix_x, pix_x_q;
  logic [YW-1:0]           pix_y, pix_y_q;
  logic                    last_q;
  logic                    pop, emit;

  assign {e_x_inc, e_y_inc, e_sx, e_sy, e_steps} = entry_i;

  assign emit          = busy_q && (!out_valid_q || out_ready_i);
  assign pop           = !busy_q && entry_valid_i;
  assign entry_ready_o = !busy_q;

  always_comb begin
    pix_x = x_acc_q[XAW-1] ? '0 : x_acc_q[FRACTION_BITS +: XW];
    pix_y = y_acc_q[YAW-1] ? '0 : y_acc_q[FRACTION_BITS +: YW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        busy_q <= 1'b1;
        left_q <= COUNT_W'(e_steps) + COUNT_W'(1);
      end else if (emit) begin
        left_q <= left_q - COUNT_W'(1);
        if (left_q == COUNT_W'(1)) busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      x_acc_q <= $signed({1'b0, e_sx, 1'b1, {(FRACTION_BITS - 1){1'b0}}});
      y_acc_q <= $signed({1'b0, e_sy, 1'b1, {(FRACTION_BITS - 1){1'b0}}});
      x_inc_q <= e_x_inc;
      y_inc_q <= e_y_inc;
    end else if (emit) begin
      x_acc_q <= x_acc_q + XAW'(x_inc_q);
      y_acc_q <= y_acc_q + YAW'(y_inc_q);
    end
    if (emit) begin
      pix_x_q <= pix_x;
      pix_y_q <= pix_y;
      last_q  <= (left_q == COUNT_W'(1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign last_pixel_o = last_q;

endmodule

/* hw/rtl/dda_checker.sv */
// ----------------------------------------------------------------------------
// dda_checker
// Port-level checks of the DDA line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module dda_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [dda_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dda_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  localparam int XW      = dda_pkg::XW;
  localparam int YW      = dda_pkg::YW;
  localparam int COUNT_W = dda_pkg::COUNT_W;

  logic               in_acc, out_acc;
  logic [XW-1:0]      prev_x_q, cur_x;
  logic [YW-1:0]      prev_y_q, cur_y;
  logic               mid_q;
  logic [COUNT_W-1:0] cnt_q;
  logic [3:0]         pend_q;
  logic signed [XW:0] step_x;
  logic signed [YW:0] step_y;
  logic               near;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cur_x   = m_axis_tdata[XW-1:0];
  assign cur_y   = m_axis_tdata[XW +: YW];

  always_comb begin
    step_x = $signed({1'b0, cur_x}) - $signed({1'b0, prev_x_q});
    step_y = $signed({1'b0, cur_y}) - $signed({1'b0, prev_y_q});
    near   = (step_x >= -1) && (step_x <= 1) && (step_y >= -1) && (step_y <= 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      mid_q    <= 1'b0;
      cnt_q    <= '0;
      pend_q   <= '0;
    end else begin
      if (out_acc) begin
        prev_x_q <= cur_x;
        prev_y_q <= cur_y;
        mid_q    <= !m_axis_tlast;
        cnt_q    <= m_axis_tlast ? '0 : cnt_q + COUNT_W'(1);
      end
      pend_q <= pend_q + 4'(in_acc) - 4'(out_acc && m_axis_tlast);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && mid_q |-> near)
    else $error("pixels of one segment are not adjacent");

  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> int'(cnt_q) < dda_pkg::MAX_PIXELS)
    else $error("segment longer than the canvas allows");

  a_has_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != '0)
    else $error("pixel emitted with no segment outstanding");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);
